@@ rtl/led_exp_curve_dither_macros.svh @@
// ----------------------------------------------------------------------------
// LED curve dither assertion macros
// Shared concurrent assertion forms for the LED curve dither checker.
// ----------------------------------------------------------------------------
`ifndef LED_EXP_CURVE_DITHER_MACROS_SVH
`define LED_EXP_CURVE_DITHER_MACROS_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low
`define LEDCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle while arst_n is low
`define LEDCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ledcd_pkg.sv @@
// ----------------------------------------------------------------------------
// LED curve dither package
// Widths, shared types, the spread patterns and the exponential curve table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ledcd_pkg;

	localparam int LED_COUNT     = 16;
	localparam int LED_IDX_W     = $clog2(LED_COUNT);
	localparam int CURVE_ENTRIES = 256;
	localparam int IDX_W         = $clog2(CURVE_ENTRIES);
	localparam int LEVEL_MAX     = 16 * 90 - 1;
	localparam int LEVEL_W       = 11;
	localparam int REM_W         = 4;
	localparam int BASE_W        = LEVEL_W - REM_W;
	localparam int DRIVE_W       = 7;
	localparam int CURVE_SPAN    = 254;
	localparam int FRAC_BITS     = 52;

	localparam int MAXI_W        = 8;
	localparam int FRAC_W        = 9;
	localparam int PI_W          = 2 * FRAC_W;
	localparam int COMMON_W      = MAXI_W + PI_W;
	localparam int PROD_W        = COMMON_W + FRAC_W;
	localparam int SCALE_SHIFT   = 24;

	localparam logic [MAXI_W-1:0] MAXI_RESET = 8'hFF;

	typedef logic [CURVE_ENTRIES-1:0][LEVEL_W-1:0] curve_lut_t;

	// Result of one colour lane: whole level steps and the dither spread
	typedef struct packed {
		logic [BASE_W-1:0]    base;
		logic [LED_COUNT-1:0] pattern;
	} lane_res_t;

	// Load enables for the lane pipeline registers
	typedef struct packed {
		logic en_s3;
		logic en_s4;
	} lane_ctl_t;

	// Spread patterns indexed by the 4-bit remainder, highest entry first
	localparam logic [15:0][LED_COUNT-1:0] SPREAD_PATTERN = {
		16'hFBFF, 16'hFBBF, 16'hEBBF, 16'hEBBE,
		16'hABBE, 16'hABBA, 16'hAABA, 16'hAAAA,
		16'h2AAA, 16'h2A8A, 16'h2A0A, 16'h0A0A,
		16'h020A, 16'h0208, 16'h0008, 16'h0000
	};

	// Fixed-point product (a*b) >> FRAC_BITS, kept to 64 bits
	function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[FRAC_BITS+63:FRAC_BITS];
	endfunction

	// True when r raised to CURVE_SPAN stays at or below LEVEL_MAX
	function automatic logic root_fits(input logic [63:0] r);
		logic [63:0] limit;
		logic [63:0] p;
		logic        fits;
		limit = 64'(LEVEL_MAX) << FRAC_BITS;
		p     = 64'd1 << FRAC_BITS;
		fits  = 1'b1;
		for (int k = 0; k < CURVE_SPAN; k++) begin
			if (fits) begin
				p = fx_mul(p, r);
				if (p > limit)
					fits = 1'b0;
			end
		end
		return fits;
	endfunction

	// Curve table, worked out at elaboration in Q12.52
	function automatic curve_lut_t build_curve();
		curve_lut_t  lut;
		logic [63:0] one;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] y;
		logic [63:0] eps;
		logic [63:0] lvl;
		one = 64'd1 << FRAC_BITS;
		lo  = one;
		hi  = one + (one >> 4);
		eps = 64'd1 << (FRAC_BITS - 30);
		// largest root whose power chain still fits
		for (int it = 0; it < 64; it++) begin
			if (hi - lo > 64'd1) begin
				mid = lo + ((hi - lo) >> 1);
				if (root_fits(mid))
					lo = mid;
				else
					hi = mid;
			end
		end
		lut[0] = '0;
		lut[1] = LEVEL_W'(1);
		y = one;
		for (int x = 2; x < CURVE_ENTRIES; x++) begin
			y   = fx_mul(y, lo);
			lvl = (y + eps) >> FRAC_BITS;
			if (lvl > 64'(LEVEL_MAX))
				lvl = 64'(LEVEL_MAX);
			lut[x] = lvl[LEVEL_W-1:0];
		end
		return lut;
	endfunction

	localparam curve_lut_t CURVE_LUT = build_curve();

endpackage

@@ rtl/ledcd_lane.sv @@
// ----------------------------------------------------------------------------
// LED curve dither colour lane
// Scales one colour fraction, saturates the curve index, looks up the level
// and splits it into base and spread pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ledcd_lane (
	input  logic                                clk,
	input  ledcd_pkg::lane_ctl_t                ctl,
	input  logic [ledcd_pkg::COMMON_W-1:0]      common_s2,
	input  logic [ledcd_pkg::FRAC_W-1:0]        colour_s2,
	output ledcd_pkg::lane_res_t                res_s4
);

	logic [ledcd_pkg::PROD_W-1:0]  prod_s3;
	logic [ledcd_pkg::IDX_W-1:0]   curve_idx;
	logic [ledcd_pkg::LEVEL_W-1:0] level;

	always_ff @(posedge clk) begin
		if (ctl.en_s3)
			prod_s3 <= ledcd_pkg::PROD_W'(common_s2) * ledcd_pkg::PROD_W'(colour_s2);
	end

	// clamp indexes past the table end to its last entry
	always_comb begin
		if (|prod_s3[ledcd_pkg::PROD_W-1:ledcd_pkg::SCALE_SHIFT+ledcd_pkg::IDX_W])
			curve_idx = '1;
		else
			curve_idx = prod_s3[ledcd_pkg::SCALE_SHIFT+ledcd_pkg::IDX_W-1:ledcd_pkg::SCALE_SHIFT];
	end

	assign level = ledcd_pkg::CURVE_LUT[curve_idx];

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			res_s4.base    <= level[ledcd_pkg::LEVEL_W-1:ledcd_pkg::REM_W];
			res_s4.pattern <= ledcd_pkg::SPREAD_PATTERN[level[ledcd_pkg::REM_W-1:0]];
		end
	end

endmodule

@@ rtl/ledcd_seq.sv @@
// ----------------------------------------------------------------------------
// LED curve dither merge and sequencer
// Holds the three lane results of one frame and steps through the LEDs,
// adding each LED's dither bit to the base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ledcd_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                lane_valid,
	output logic                                lane_ready,
	input  ledcd_pkg::lane_res_t                red_res,
	input  ledcd_pkg::lane_res_t                green_res,
	input  ledcd_pkg::lane_res_t                blue_res,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ledcd_pkg::LED_IDX_W-1:0]     led_index,
	output logic [ledcd_pkg::DRIVE_W-1:0]       led_red,
	output logic [ledcd_pkg::DRIVE_W-1:0]       led_green,
	output logic [ledcd_pkg::DRIVE_W-1:0]       led_blue,
	output logic                                last_led
);

	ledcd_pkg::lane_res_t                red_q;
	ledcd_pkg::lane_res_t                green_q;
	ledcd_pkg::lane_res_t                blue_q;
	logic [ledcd_pkg::LED_IDX_W-1:0]     cnt_q;
	logic                                frame_v_q;
	logic                                is_last;
	logic                                load;

	assign is_last    = (cnt_q == ledcd_pkg::LED_IDX_W'(ledcd_pkg::LED_COUNT - 1));
	assign lane_ready = !frame_v_q || (out_ready && is_last);
	assign load       = lane_valid && lane_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_v_q <= 1'b0;
			cnt_q     <= '0;
		end else if (load) begin
			frame_v_q <= 1'b1;
			cnt_q     <= '0;
		end else if (frame_v_q && out_ready) begin
			// drop the frame after its last transfer
			if (is_last)
				frame_v_q <= 1'b0;
			else
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red_q   <= red_res;
			green_q <= green_res;
			blue_q  <= blue_res;
		end
	end

	assign out_valid = frame_v_q;
	assign led_index = cnt_q;
	assign last_led  = is_last;
	assign led_red   = red_q.base + ledcd_pkg::DRIVE_W'(red_q.pattern[cnt_q]);
	assign led_green = green_q.base + ledcd_pkg::DRIVE_W'(green_q.pattern[cnt_q]);
	assign led_blue  = blue_q.base + ledcd_pkg::DRIVE_W'(blue_q.pattern[cnt_q]);

endmodule

@@ rtl/led_exp_curve_dither.sv @@
// ----------------------------------------------------------------------------
// LED exponential curve with spatial dithering
// The first LED result of a frame follows the s1, s2, s3 and s4 registers and the sequencer's frame load.
// Throughput: one LED result per cycle while out_ready is high; set by the
// sequencer that issues the 16 LED results of a frame one after another.
// Reset: arst_n clears all valids and sets the full-scale index to 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_exp_curve_dither (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ledcd_pkg::MAXI_W-1:0]        cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ledcd_pkg::FRAC_W-1:0]        power_level,
	input  logic [ledcd_pkg::FRAC_W-1:0]        intensity_level,
	input  logic [ledcd_pkg::FRAC_W-1:0]        red_level,
	input  logic [ledcd_pkg::FRAC_W-1:0]        green_level,
	input  logic [ledcd_pkg::FRAC_W-1:0]        blue_level,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ledcd_pkg::LED_IDX_W-1:0]     led_index,
	output logic [ledcd_pkg::DRIVE_W-1:0]       led_red,
	output logic [ledcd_pkg::DRIVE_W-1:0]       led_green,
	output logic [ledcd_pkg::DRIVE_W-1:0]       led_blue,
	output logic                                last_led
);

	logic [ledcd_pkg::MAXI_W-1:0]   full_scale_q;

	logic                           v_s1, v_s2, v_s3, v_s4;
	logic                           rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic                           seq_ready;

	logic [ledcd_pkg::PI_W-1:0]     pi_s1;
	logic [ledcd_pkg::FRAC_W-1:0]   red_s1, green_s1, blue_s1;
	logic [ledcd_pkg::COMMON_W-1:0] common_s2;
	logic [ledcd_pkg::FRAC_W-1:0]   red_s2, green_s2, blue_s2;

	ledcd_pkg::lane_ctl_t           lane_ctl;
	ledcd_pkg::lane_res_t           red_res_s4, green_res_s4, blue_res_s4;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			full_scale_q <= ledcd_pkg::MAXI_RESET;
		else if (cfg_valid && cfg_ready)
			full_scale_q <= cfg_data;
	end

	// a stage takes new data when empty or when its successor takes its own
	assign rdy_s4   = !v_s4 || seq_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= in_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (rdy_s3)
				v_s3 <= v_s2;
			if (rdy_s4)
				v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			pi_s1    <= ledcd_pkg::PI_W'(power_level) * ledcd_pkg::PI_W'(intensity_level);
			red_s1   <= red_level;
			green_s1 <= green_level;
			blue_s1  <= blue_level;
		end
		if (rdy_s2) begin
			common_s2 <= ledcd_pkg::COMMON_W'(full_scale_q) * ledcd_pkg::COMMON_W'(pi_s1);
			red_s2    <= red_s1;
			green_s2  <= green_s1;
			blue_s2   <= blue_s1;
		end
	end

	assign lane_ctl.en_s3 = rdy_s3;
	assign lane_ctl.en_s4 = rdy_s4;

	ledcd_lane u_lane_red (
		.clk       (clk),
		.ctl       (lane_ctl),
		.common_s2 (common_s2),
		.colour_s2 (red_s2),
		.res_s4    (red_res_s4)
	);

	ledcd_lane u_lane_green (
		.clk       (clk),
		.ctl       (lane_ctl),
		.common_s2 (common_s2),
		.colour_s2 (green_s2),
		.res_s4    (green_res_s4)
	);

	ledcd_lane u_lane_blue (
		.clk       (clk),
		.ctl       (lane_ctl),
		.common_s2 (common_s2),
		.colour_s2 (blue_s2),
		.res_s4    (blue_res_s4)
	);

	ledcd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_valid (v_s4),
		.lane_ready (seq_ready),
		.red_res    (red_res_s4),
		.green_res  (green_res_s4),
		.blue_res   (blue_res_s4),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.led_index  (led_index),
		.led_red    (led_red),
		.led_green  (led_green),
		.led_blue   (led_blue),
		.last_led   (last_led)
	);

endmodule

@@ rtl/ledcd_checker.sv @@
// ----------------------------------------------------------------------------
// LED curve dither port checker
// Watches the top-level ports for result ordering, range and hold rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "led_exp_curve_dither_macros.svh"

module ledcd_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [ledcd_pkg::LED_IDX_W-1:0]     led_index,
	input  logic [ledcd_pkg::DRIVE_W-1:0]       led_red,
	input  logic [ledcd_pkg::DRIVE_W-1:0]       led_green,
	input  logic [ledcd_pkg::DRIVE_W-1:0]       led_blue,
	input  logic                                last_led
);

	// hold a stalled result unchanged
	`LEDCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(led_index) && $stable(led_red) && $stable(led_green) && $stable(led_blue), "stalled LED result changed")

	// advance through the strip one LED per transfer
	`LEDCD_ASSERT_NEXT(a_index_step, out_valid && out_ready && !last_led, out_valid && (led_index == ledcd_pkg::LED_IDX_W'($past(led_index) + 1'b1)), "LED index did not advance by one within a frame")

	// start every following frame at the first LED
	`LEDCD_ASSERT_NEXT(a_frame_restart, out_valid && out_ready && last_led, !out_valid || (led_index == '0), "new frame did not start at LED zero")

	// keep drive values within the curve range
	`LEDCD_ASSERT_NOW(a_drive_range, out_valid, (led_red <= 7'd90) && (led_green <= 7'd90) && (led_blue <= 7'd90), "LED drive value above 90")

endmodule

bind led_exp_curve_dither ledcd_checker u_ledcd_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED curve dither testbench
// Sends frames of power, intensity and colour fractions through the block,
// predicts the sixteen dithered LED drive values of each frame from an
// exponential curve rebuilt here in Q12.52, and checks every LED result in
// order. Random stalls on both sides, several full-scale settings.
// ----------------------------------------------------------------------------

module tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          DRAIN_WAIT  = 8;

	typedef struct packed {
		logic [ledcd_pkg::FRAC_W-1:0] power;
		logic [ledcd_pkg::FRAC_W-1:0] intensity;
		logic [ledcd_pkg::FRAC_W-1:0] red;
		logic [ledcd_pkg::FRAC_W-1:0] green;
		logic [ledcd_pkg::FRAC_W-1:0] blue;
	} frame_t;

	typedef struct packed {
		logic [ledcd_pkg::LED_IDX_W-1:0] index;
		logic [ledcd_pkg::DRIVE_W-1:0]   red;
		logic [ledcd_pkg::DRIVE_W-1:0]   green;
		logic [ledcd_pkg::DRIVE_W-1:0]   blue;
		logic                            last_led;
	} led_t;

	class dither_scoreboard;
		logic [10:0]                  brightness_curve [ledcd_pkg::CURVE_ENTRIES];
		logic [15:0]                  spread [16];
		logic [ledcd_pkg::MAXI_W-1:0] full_scale;
		led_t                         pending_leds [$];
		int unsigned                  mismatches;

		function new();
			spread = '{16'h0000, 16'h0008, 16'h0208, 16'h020A,
				16'h0A0A, 16'h2A0A, 16'h2A8A, 16'h2AAA,
				16'hAAAA, 16'hAABA, 16'hABBA, 16'hABBE,
				16'hEBBE, 16'hEBBF, 16'hFBBF, 16'hFBFF};
			full_scale = ledcd_pkg::MAXI_RESET;
			mismatches = 0;
			build_curve();
		endfunction

		function logic [63:0] q52_mul(logic [63:0] a, logic [63:0] b);
			logic [127:0] wide;
			wide = {64'd0, a} * {64'd0, b};
			return wide[ledcd_pkg::FRAC_BITS+63:ledcd_pkg::FRAC_BITS];
		endfunction

		// true while root^CURVE_SPAN stays at or below the top level
		function bit span_fits(logic [63:0] root);
			logic [63:0] acc;
			logic [63:0] ceiling;
			ceiling = 64'(ledcd_pkg::LEVEL_MAX) << ledcd_pkg::FRAC_BITS;
			acc = 64'd1 << ledcd_pkg::FRAC_BITS;
			for (int k = 0; k < ledcd_pkg::CURVE_SPAN; k++) begin
				acc = q52_mul(acc, root);
				if (acc > ceiling)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void build_curve();
			logic [63:0] one;
			logic [63:0] lo;
			logic [63:0] hi;
			logic [63:0] mid;
			logic [63:0] y;
			logic [63:0] lvl;
			one = 64'd1 << ledcd_pkg::FRAC_BITS;
			lo = one;
			hi = one + (one >> 4);
			// bisect for the largest per-step growth factor
			while (hi - lo > 64'd1) begin
				mid = lo + ((hi - lo) >> 1);
				if (span_fits(mid))
					lo = mid;
				else
					hi = mid;
			end
			brightness_curve[0] = 11'd0;
			brightness_curve[1] = 11'd1;
			y = one;
			for (int x = 2; x < ledcd_pkg::CURVE_ENTRIES; x++) begin
				y = q52_mul(y, lo);
				lvl = (y + (64'd1 << (ledcd_pkg::FRAC_BITS - 30))) >> ledcd_pkg::FRAC_BITS;
				if (lvl > 64'(ledcd_pkg::LEVEL_MAX))
					lvl = 64'(ledcd_pkg::LEVEL_MAX);
				brightness_curve[x] = lvl[10:0];
			end
		endfunction

		function logic [10:0] channel_level(logic [25:0] common,
			logic [ledcd_pkg::FRAC_W-1:0] colour);
			logic [34:0] idx;
			idx = common * colour;
			idx = idx >> ledcd_pkg::SCALE_SHIFT;
			if (idx > ledcd_pkg::CURVE_ENTRIES - 1)
				idx = ledcd_pkg::CURVE_ENTRIES - 1;
			return brightness_curve[idx[7:0]];
		endfunction

		function void note_frame(frame_t f);
			logic [25:0] common;
			logic [10:0] lvl_r;
			logic [10:0] lvl_g;
			logic [10:0] lvl_b;
			led_t        e;
			common = full_scale * f.power * f.intensity;
			lvl_r = channel_level(common, f.red);
			lvl_g = channel_level(common, f.green);
			lvl_b = channel_level(common, f.blue);
			for (int i = 0; i < ledcd_pkg::LED_COUNT; i++) begin
				e.index = ledcd_pkg::LED_IDX_W'(i);
				e.red = lvl_r[10:4] + spread[lvl_r[3:0]][i];
				e.green = lvl_g[10:4] + spread[lvl_g[3:0]][i];
				e.blue = lvl_b[10:4] + spread[lvl_b[3:0]][i];
				e.last_led = (i == ledcd_pkg::LED_COUNT - 1);
				pending_leds.push_back(e);
			end
		endfunction

		function void check_led(led_t got);
			led_t want;
			if (pending_leds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected LED result: idx %0d r %0d g %0d b %0d last %0d",
						got.index, got.red, got.green, got.blue, got.last_led);
				return;
			end
			want = pending_leds.pop_front();
			if (want.index !== got.index || want.red !== got.red || want.green !== got.green
				|| want.blue !== got.blue || want.last_led !== got.last_led) begin
				mismatches++;
				if (mismatches <= 10)
					$display("LED mismatch: exp idx %0d r %0d g %0d b %0d last %0d, got idx %0d r %0d g %0d b %0d last %0d",
						want.index, want.red, want.green, want.blue, want.last_led,
						got.index, got.red, got.green, got.blue, got.last_led);
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [ledcd_pkg::MAXI_W-1:0]    cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [ledcd_pkg::FRAC_W-1:0]    power_level = '0;
	logic [ledcd_pkg::FRAC_W-1:0]    intensity_level = '0;
	logic [ledcd_pkg::FRAC_W-1:0]    red_level = '0;
	logic [ledcd_pkg::FRAC_W-1:0]    green_level = '0;
	logic [ledcd_pkg::FRAC_W-1:0]    blue_level = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [ledcd_pkg::LED_IDX_W-1:0] led_index;
	logic [ledcd_pkg::DRIVE_W-1:0]   led_red;
	logic [ledcd_pkg::DRIVE_W-1:0]   led_green;
	logic [ledcd_pkg::DRIVE_W-1:0]   led_blue;
	logic                            last_led;

	bit                              steady = 1'b0;
	int unsigned                     cycle_count = 0;
	dither_scoreboard                sb = new();

	led_exp_curve_dither dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.power_level     (power_level),
		.intensity_level (intensity_level),
		.red_level       (red_level),
		.green_level     (green_level),
		.blue_level      (blue_level),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.led_index       (led_index),
		.led_red         (led_red),
		.led_green       (led_green),
		.led_blue        (led_blue),
		.last_led        (last_led)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// watch every transfer on the three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.full_scale = cfg_data;
			if (in_valid && in_ready)
				sb.note_frame('{power_level, intensity_level, red_level, green_level, blue_level});
			if (out_valid && out_ready)
				sb.check_led('{led_index, led_red, led_green, led_blue, last_led});
		end
	end

	// result side: ready in bursts, with random stalls unless steady
	initial begin
		wait (arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (!steady) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	function automatic frame_t mk_frame(int p, int i, int r, int g, int b);
		frame_t f;
		f.power = ledcd_pkg::FRAC_W'(p);
		f.intensity = ledcd_pkg::FRAC_W'(i);
		f.red = ledcd_pkg::FRAC_W'(r);
		f.green = ledcd_pkg::FRAC_W'(g);
		f.blue = ledcd_pkg::FRAC_W'(b);
		return f;
	endfunction

	function automatic logic [ledcd_pkg::FRAC_W-1:0] pick_level(bit lean_high);
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return 9'd256;
		if (r <= 3)
			return ledcd_pkg::FRAC_W'($urandom_range(257, 511));
		if (r == 4)
			return ledcd_pkg::FRAC_W'($urandom_range(0, 511));
		// keep power and intensity high enough to reach the top of the curve
		if (lean_high && r < 14)
			return ledcd_pkg::FRAC_W'($urandom_range(160, 256));
		return ledcd_pkg::FRAC_W'($urandom_range(0, 256));
	endfunction

	task automatic send_frame(frame_t f, int gap_pct);
		if (!steady && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		power_level <= f.power;
		intensity_level <= f.intensity;
		red_level <= f.red;
		green_level <= f.green;
		blue_level <= f.blue;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic run_phase(int count, int gap_pct);
		for (int k = 0; k < count; k++)
			send_frame(mk_frame(pick_level(1'b1), pick_level(1'b1), pick_level(1'b0),
				pick_level(1'b0), pick_level(1'b0)), gap_pct);
	endtask

	// hold off until every LED of earlier frames is out, then write
	task automatic write_full_scale(logic [ledcd_pkg::MAXI_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_leds.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes at the reset full scale, including saturation above 1.0
		send_frame(mk_frame(0, 0, 0, 0, 0), 30);
		send_frame(mk_frame(256, 256, 256, 256, 256), 30);
		send_frame(mk_frame(511, 511, 511, 511, 511), 30);
		send_frame(mk_frame(256, 256, 1, 2, 256), 30);
		send_frame(mk_frame(511, 1, 256, 511, 0), 30);
		// sweep the curve index so the remainders and patterns all turn up
		for (int k = 0; k < 16; k++)
			send_frame(mk_frame(256, 256, 16 * k + 1, 16 * k + 8, 255 - 16 * k), 30);

		run_phase(80, 25);
		write_full_scale(8'd0);
		run_phase(30, 20);
		write_full_scale(8'd1);
		run_phase(30, 0);
		write_full_scale(8'd128);
		run_phase(80, 30);
		write_full_scale(ledcd_pkg::MAXI_W'($urandom_range(2, 254)));
		run_phase(80, 15);
		write_full_scale(8'd255);
		run_phase(60, 25);

		steady = 1'b1;
		run_phase(60, 0);
		in_valid <= 1'b0;
		@(posedge clk);

		while (sb.pending_leds.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_leds.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
